### sv/sccc_pkg.sv
// Shared constants and types for the snooping coherence controller.
// No dependencies.
package sccc_pkg;

    localparam int unsigned DEF_SETS       = 256;
    localparam int unsigned DEF_WAYS       = 4;
    localparam int unsigned DEF_LINE_BYTES = 64;
    localparam int unsigned ADDR_W         = 32;

    localparam logic [2:0] ST_INV = 3'd0;
    localparam logic [2:0] ST_EXC = 3'd1;
    localparam logic [2:0] ST_MOD = 3'd2;
    localparam logic [2:0] ST_SHC = 3'd3;
    localparam logic [2:0] ST_SHM = 3'd4;

    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_RD    = 2'd1;
    localparam logic [1:0] BUS_UPD   = 2'd2;
    localparam logic [1:0] BUS_RDUPD = 2'd3;

    localparam logic [2:0] MODE_RD     = 3'd0;
    localparam logic [2:0] MODE_WR     = 3'd1;
    localparam logic [2:0] MODE_SRD    = 3'd2;
    localparam logic [2:0] MODE_SUPD   = 3'd3;
    localparam logic [2:0] MODE_SRDUPD = 3'd4;

    localparam logic [0:0] REG_PROTOCOL = 1'd0;

    // controller -> datapath
    typedef struct packed {
        logic rd_set;    // read the set
        logic resolve;   // compute result, write back, load output
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_full;
    } t_dp_sts;

    typedef struct packed {
        logic       hit;
        logic [2:0] line_state;
        logic [1:0] bus_op;
        logic       writeback;
        logic       memory_supply;
        logic       cache_transfer;
    } t_result;

endpackage

### sv/sccc_ctrl.sv
// Sequencer for the coherence controller: read cycle then resolve cycle.
// Depends on sccc_pkg.
module sccc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output sccc_pkg::t_dp_cmd o_cmd,
    input  sccc_pkg::t_dp_sts i_sts
);
    typedef enum logic {S_IDLE, S_RESOLVE} t_state;
    t_state r_state;

    assign o_ready      = i_rst_n && (r_state == S_IDLE);
    assign o_cmd.rd_set = o_ready && i_valid;
    assign o_cmd.resolve = (r_state == S_RESOLVE) && !i_sts.out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:    if (i_valid) r_state <= S_RESOLVE;
                S_RESOLVE: if (!i_sts.out_full) r_state <= S_IDLE;
                default:   r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### sv/sccc_dpath.sv
// Tag/state/age storage, lookup, replacement and protocol update datapath.
// Depends on sccc_pkg.
module sccc_dpath #(
    parameter int unsigned SETS       = sccc_pkg::DEF_SETS,
    parameter int unsigned WAYS       = sccc_pkg::DEF_WAYS,
    parameter int unsigned LINE_BYTES = sccc_pkg::DEF_LINE_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sccc_pkg::t_dp_cmd i_cmd,
    output sccc_pkg::t_dp_sts o_sts,
    input  logic [2:0]        i_mode,
    input  logic [31:0]       i_address,
    input  logic              i_shared_line,
    input  logic              i_dragon,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output sccc_pkg::t_result o_res
);
    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int TAG_W = sccc_pkg::ADDR_W - OFF_W - ((SETS > 1) ? $clog2(SETS) : 0);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W = WAY_W;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [2:0]       st;
        logic [AGE_W-1:0] age;
    } t_entry;

    // one row per set, single port; valid bit per set stands for reset
    t_entry [WAYS-1:0] r_mem [SETS];
    logic   [SETS-1:0] r_row_ok;
    t_entry [WAYS-1:0] r_rd;
    t_entry [WAYS-1:0] rd_row;
    logic              r_rd_ok;
    logic   [IDX_W-1:0] r_idx;
    logic   [TAG_W-1:0] r_tag;
    logic   [2:0]       r_mode;
    logic               r_sh;
    logic               r_out_valid;
    sccc_pkg::t_result  r_res;

    logic [IDX_W-1:0] in_idx;
    logic [TAG_W-1:0] in_tag;
    assign in_idx = (SETS > 1) ? IDX_W'(i_address[31:OFF_W] % SETS) : '0;
    assign in_tag = TAG_W'(i_address[31:OFF_W] / SETS);

    always_comb begin
        for (int j = 0; j < WAYS; j++) begin
            rd_row[j] = r_rd[j];
            if (!r_rd_ok) begin
                rd_row[j].st  = sccc_pkg::ST_INV;
                rd_row[j].age = '0;
            end
        end
    end

    // lookup and update
    t_entry [WAYS-1:0] new_row;
    sccc_pkg::t_result res;
    logic               hit;
    logic [WAY_W-1:0]   w;
    logic               has_inv;
    logic [WAY_W-1:0]   inv_w;
    logic [WAY_W-1:0]   lru_w;
    logic [AGE_W-1:0]   best;
    logic [2:0]         s;
    logic               touch;
    logic               was_valid;
    logic               rd_m;
    logic               up_m;
    logic               wr_m;

    always_comb begin
        new_row = rd_row;
        res = '0;
        hit = 1'b0; w = '0; has_inv = 1'b0; inv_w = '0; lru_w = '0; best = '0;
        touch = 1'b0; was_valid = 1'b1;
        rd_m = (r_mode == sccc_pkg::MODE_SRD) || (r_mode == sccc_pkg::MODE_SRDUPD);
        up_m = (r_mode == sccc_pkg::MODE_SUPD) || (r_mode == sccc_pkg::MODE_SRDUPD);
        wr_m = (r_mode == sccc_pkg::MODE_WR);
        for (int j = WAYS - 1; j >= 0; j--) begin
            if (rd_row[j].st != sccc_pkg::ST_INV && rd_row[j].tag == r_tag) begin
                hit = 1'b1; w = WAY_W'(j);
            end
            if (rd_row[j].st == sccc_pkg::ST_INV) begin
                has_inv = 1'b1; inv_w = WAY_W'(j);
            end
        end
        for (int j = 0; j < WAYS; j++) begin
            if (rd_row[j].age > best) begin
                best = rd_row[j].age; lru_w = WAY_W'(j);
            end
        end
        s = rd_row[w].st;
        if (r_mode > sccc_pkg::MODE_SRDUPD) begin
            res = '0;
        end else if (r_mode >= sccc_pkg::MODE_SRD) begin
            if (hit) begin
                res.hit = 1'b1;
                if (i_dragon) begin
                    if (rd_m) begin
                        if (s == sccc_pkg::ST_EXC) s = sccc_pkg::ST_SHC;
                        else if (s == sccc_pkg::ST_MOD) s = sccc_pkg::ST_SHM;
                    end
                    if (up_m && s == sccc_pkg::ST_SHM) s = sccc_pkg::ST_SHC;
                end else if (rd_m) begin
                    if (s == sccc_pkg::ST_EXC) s = sccc_pkg::ST_SHC;
                    else if (s == sccc_pkg::ST_MOD) begin
                        s = sccc_pkg::ST_SHC; res.memory_supply = 1'b1;
                    end
                end
                new_row[w].st = s;
                res.line_state = s;
            end
        end else if (hit) begin
            res.hit = 1'b1;
            touch = 1'b1;
            if (i_dragon) begin
                if (wr_m) begin
                    if (s == sccc_pkg::ST_EXC) s = sccc_pkg::ST_MOD;
                    else if (s == sccc_pkg::ST_SHC || s == sccc_pkg::ST_SHM) begin
                        if (r_sh) begin
                            s = sccc_pkg::ST_SHM; res.bus_op = sccc_pkg::BUS_UPD;
                        end else s = sccc_pkg::ST_MOD;
                    end
                end
            end else if (wr_m) begin
                if (s == sccc_pkg::ST_EXC) s = sccc_pkg::ST_MOD;
                else if (s == sccc_pkg::ST_SHC) begin
                    res.memory_supply = 1'b1;
                    if (!r_sh) s = sccc_pkg::ST_MOD;
                end
            end
            new_row[w].st = s;
            res.line_state = s;
        end else begin
            touch = 1'b1;
            if (has_inv) begin
                w = inv_w; was_valid = 1'b0;
            end else begin
                w = lru_w;
            end
            if (rd_row[w].st == sccc_pkg::ST_MOD || rd_row[w].st == sccc_pkg::ST_SHM)
                res.writeback = 1'b1;
            new_row[w].tag = r_tag;
            if (i_dragon) begin
                if (wr_m) begin
                    if (r_sh) begin
                        s = sccc_pkg::ST_SHM; res.bus_op = sccc_pkg::BUS_RDUPD;
                        res.cache_transfer = 1'b1;
                    end else begin
                        s = sccc_pkg::ST_MOD; res.bus_op = sccc_pkg::BUS_RD;
                        res.memory_supply = 1'b1;
                    end
                end else begin
                    res.bus_op = sccc_pkg::BUS_RD;
                    if (r_sh) begin
                        s = sccc_pkg::ST_SHC; res.cache_transfer = 1'b1;
                    end else begin
                        s = sccc_pkg::ST_EXC; res.memory_supply = 1'b1;
                    end
                end
            end else if (r_sh) begin
                s = sccc_pkg::ST_SHC; res.bus_op = sccc_pkg::BUS_RD;
                res.cache_transfer = 1'b1;
                if (wr_m) res.memory_supply = 1'b1;
            end else begin
                s = wr_m ? sccc_pkg::ST_MOD : sccc_pkg::ST_EXC;
                res.memory_supply = 1'b1;
            end
            new_row[w].st = s;
            res.line_state = s;
        end
        if (touch) begin
            for (int j = 0; j < WAYS; j++) begin
                if (WAY_W'(j) != w && rd_row[j].st != sccc_pkg::ST_INV &&
                    (!was_valid || rd_row[j].age < rd_row[w].age) &&
                    rd_row[j].age < AGE_W'(WAYS - 1))
                    new_row[j].age = rd_row[j].age + AGE_W'(1);
            end
            new_row[w].age = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_set) begin
            r_rd    <= r_mem[in_idx];
            r_rd_ok <= r_row_ok[in_idx];
            r_idx   <= in_idx;
            r_tag   <= in_tag;
            r_mode  <= i_mode;
            r_sh    <= i_shared_line;
        end
        if (i_cmd.resolve) begin
            r_mem[r_idx] <= new_row;
            r_res        <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.resolve) begin
                r_row_ok[r_idx] <= 1'b1;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_res          = r_res;

    a_miss_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.hit && r_res.line_state != sccc_pkg::ST_INV |->
        r_res.bus_op != sccc_pkg::BUS_NONE || r_res.memory_supply)
        else $error("miss result without bus or memory activity");
    a_no_ow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_res))
        else $error("pending result overwritten");
    a_wb_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.writeback |-> !r_res.hit)
        else $error("writeback on hit");
    a_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.cache_transfer |-> r_res.bus_op != sccc_pkg::BUS_NONE)
        else $error("cache transfer without bus op");
endmodule

### sv/snooping_cache_coherence_controller_core.sv
// Each item first reads the set's row (tags, states and ages of all ways)
// from single-port storage, then resolves it, writes the row back and loads
// the output register. A new word is accepted whenever the sequencer is
// idle; the resolve step waits while the output register still holds an
// undrained word, and the input stalls until that resolve is done.
// Reset invalidates all sets at once via per-set valid bits; no sweep.
module snooping_cache_coherence_controller_core #(
    parameter int unsigned SETS       = sccc_pkg::DEF_SETS,
    parameter int unsigned WAYS       = sccc_pkg::DEF_WAYS,
    parameter int unsigned LINE_BYTES = sccc_pkg::DEF_LINE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_address,
    input  logic        i_shared_line,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [2:0]  o_line_state,
    output logic [1:0]  o_bus_op,
    output logic        o_writeback,
    output logic        o_memory_supply,
    output logic        o_cache_transfer,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [1:0] PROTOCOL_ADDR = 2'({sccc_pkg::REG_PROTOCOL, 2'b00});

    sccc_pkg::t_dp_cmd cmd;
    sccc_pkg::t_dp_sts sts;
    sccc_pkg::t_result res;
    logic r_protocol;

    assign pready = 1'b1;
    assign prdata = (paddr == PROTOCOL_ADDR) ? {31'd0, r_protocol} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol <= 1'b1;
        end else if (psel && penable && pwrite && paddr == PROTOCOL_ADDR) begin
            r_protocol <= pwdata[0];
        end
    end

    sccc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_cmd(cmd), .i_sts(sts)
    );

    sccc_dpath #(.SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES)) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_mode(i_mode), .i_address(i_address), .i_shared_line(i_shared_line),
        .i_dragon(r_protocol), .i_out_ready(i_ready), .o_out_valid(o_valid),
        .o_res(res)
    );

    assign o_hit            = res.hit;
    assign o_line_state     = res.line_state;
    assign o_bus_op         = res.bus_op;
    assign o_writeback      = res.writeback;
    assign o_memory_supply  = res.memory_supply;
    assign o_cache_transfer = res.cache_transfer;
endmodule
